[sv/pefc_pkg.sv]
// Package: constants, codes and shared types of the polygon edge facing classifier.
`default_nettype none
package pefc_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int COORD_W      = 16;
    localparam int VCNT_W       = 5;
    localparam int MASK_W       = 16;
    localparam int CNT_W        = 5;
    localparam int OPND_W       = COORD_W + 2;
    localparam int PROD_W       = 2 * OPND_W;
    localparam int ACC_W        = PROD_W + 2;
    localparam int VTX_W        = 2 * COORD_W;

    localparam logic [VCNT_W-1:0] VCNT_MIN   = VCNT_W'(3);
    localparam logic [VCNT_W-1:0] VCNT_MAX   = VCNT_W'(MAX_VERTICES);
    localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(3);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             is_edge;
        logic             part;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } pefc_op_t;

    typedef struct packed {
        logic             valid;
        logic             facing;
        logic             last;
        logic [IDX_W-1:0] idx;
    } pefc_res_t;

endpackage
`default_nettype wire

[sv/polygon_edge_facing_classifier.sv]
// Top level: command port, vertex count register, query sequencer and result registers.
// Load command: written into the vertex store on its transfer, busy stays low.
// Query: done pulses when the last edge test of the n vertices in use leaves the datapath;
// busy stays high until that cycle, so no new query is taken before the last one is through,
// as the single shared multiplier serves every op (one per edge for the winding sum, two per edge test).
// Reset (rst_n low, asynchronous) idles the sequencer and sets vertex_count to 3;
// the vertex store is not cleared. The receiver cannot stall: done lasts one cycle.
`default_nettype none
module polygon_edge_facing_classifier
    import pefc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               command,
    input  wire logic [IDX_W-1:0]   vertex_index,
    input  wire logic [COORD_W-1:0] coord_x,
    input  wire logic [COORD_W-1:0] coord_y,
    output logic                    done,
    output logic [MASK_W-1:0]       facing_mask,
    output logic [CNT_W-1:0]        facing_count,
    output logic                    is_clockwise,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [VCNT_W-1:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WIND  = 2'd1;
    localparam logic [1:0] ST_EDGE  = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next, idx_succ, last_idx_reg, last_idx_next;
    logic               part_reg, part_next;
    logic [VCNT_W-1:0]  vcnt_reg, vcnt_used;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               done_reg;
    logic [MASK_W-1:0]  mask_out_reg;
    logic [CNT_W-1:0]   count_out_reg;
    logic               cw_out_reg;
    logic               take_load, take_query;
    logic [VTX_W-1:0]   vtx_a, vtx_b;
    pefc_op_t           op;
    pefc_res_t          res;
    logic               cw;

    assign take_load  = start && !busy && (command == CMD_LOAD);
    assign take_query = start && !busy && (command == CMD_QUERY);
    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        if (vcnt_reg < VCNT_MIN)
        begin
            vcnt_used = VCNT_MIN;
        end
        else if (vcnt_reg > VCNT_MAX)
        begin
            vcnt_used = VCNT_MAX;
        end
        else
        begin
            vcnt_used = vcnt_reg;
        end
    end

    assign idx_succ = (idx_reg == last_idx_reg) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        part_next     = part_reg;
        last_idx_next = last_idx_reg;
        op            = '0;
        op.idx        = idx_reg;
        op.part       = part_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_query)
                begin
                    last_idx_next = IDX_W'(vcnt_used - 1'b1);
                    idx_next      = '0;
                    part_next     = 1'b0;
                    state_next    = ST_WIND;
                end
            end
            ST_WIND:
            begin
                op.valid = 1'b1;
                op.first = (idx_reg == '0);
                op.last  = (idx_reg == last_idx_reg);
                idx_next = idx_succ;
                if (idx_reg == last_idx_reg)
                begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                op.valid   = 1'b1;
                op.is_edge = 1'b1;
                op.last    = part_reg && (idx_reg == last_idx_reg);
                part_next  = !part_reg;
                if (part_reg)
                begin
                    idx_next = idx_succ;
                    if (idx_reg == last_idx_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (res.valid && res.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mask_next  = mask_reg;
        count_next = count_reg;
        if (res.valid && res.facing)
        begin
            mask_next  = mask_reg | (MASK_W'(1) << res.idx);
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            part_reg     <= 1'b0;
            last_idx_reg <= '0;
            vcnt_reg     <= VCNT_RESET;
            mask_reg     <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            part_reg     <= part_next;
            last_idx_reg <= last_idx_next;
            if (cfg_valid && cfg_ready)
            begin
                vcnt_reg <= cfg_data;
            end
            if (take_query)
            begin
                mask_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                mask_reg  <= mask_next;
                count_reg <= count_next;
            end
            done_reg <= res.valid && res.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_query)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (res.valid && res.last)
        begin
            mask_out_reg  <= mask_next;
            count_out_reg <= count_next;
            cw_out_reg    <= cw;
        end
    end

    pefc_vstore u_vstore (
        .clk       (clk),
        .wr_en     (take_load),
        .wr_addr   (vertex_index),
        .wr_data   ({coord_x, coord_y}),
        .rd_addr_a (idx_reg),
        .rd_addr_b (idx_succ),
        .rd_data_a (vtx_a),
        .rd_data_b (vtx_b)
    );

    pefc_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .vtx_a (vtx_a),
        .vtx_b (vtx_b),
        .px    (px_reg),
        .py    (py_reg),
        .res   (res),
        .cw    (cw)
    );

    assign done         = done_reg;
    assign facing_mask  = mask_out_reg;
    assign facing_count = count_out_reg;
    assign is_clockwise = cw_out_reg;

endmodule
`default_nettype wire

[sv/pefc_vstore.sv]
// Vertex store: one write port, two registered read ports, {x, y} per entry.
`default_nettype none
module pefc_vstore
    import pefc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [VTX_W-1:0] wr_data,
    input  wire logic [IDX_W-1:0] rd_addr_a,
    input  wire logic [IDX_W-1:0] rd_addr_b,
    output logic      [VTX_W-1:0] rd_data_a,
    output logic      [VTX_W-1:0] rd_data_b
);

    logic [VTX_W-1:0] mem [MAX_VERTICES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
`default_nettype wire

[sv/pefc_datapath.sv]
// Shared multiply-accumulate unit: operand forming, 18x18 multiply, winding and edge sums.
`default_nettype none
module pefc_datapath
    import pefc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pefc_op_t           op,
    input  wire logic [VTX_W-1:0]   vtx_a,
    input  wire logic [VTX_W-1:0]   vtx_b,
    input  wire logic [COORD_W-1:0] px,
    input  wire logic [COORD_W-1:0] py,
    output pefc_res_t               res,
    output logic                    cw
);

    pefc_op_t op_s1_reg, op_s2_reg, op_s3_reg;

    logic signed [OPND_W-1:0] xi, yi, xj, yj, px2, py2;
    logic signed [OPND_W-1:0] opa_next, opb_next;
    logic signed [OPND_W-1:0] opa_reg, opb_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next, prod_ext, sum;
    logic                     cw_reg, cw_next;
    logic                     sum_pos, sum_neg;

    // vtx_a is vertex i, vtx_b is vertex i+1 (wrapped)
    always_comb
    begin
        xi  = OPND_W'($signed(vtx_a[VTX_W-1:COORD_W]));
        yi  = OPND_W'($signed(vtx_a[COORD_W-1:0]));
        xj  = OPND_W'($signed(vtx_b[VTX_W-1:COORD_W]));
        yj  = OPND_W'($signed(vtx_b[COORD_W-1:0]));
        px2 = OPND_W'($signed({px, 1'b0}));
        py2 = OPND_W'($signed({py, 1'b0}));
        if (!op_s1_reg.is_edge)
        begin
            opa_next = xj - xi;
            opb_next = yj + yi;
        end
        else if (!op_s1_reg.part)
        begin
            opa_next = yi - yj;
            opb_next = px2 - xi - xj;
        end
        else
        begin
            opa_next = xi - xj;
            opb_next = py2 - yi - yj;
        end
    end

    // edge sum: dx*ty - dy*tx; facing takes a positive sum for cw, a negative one for ccw
    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        sum      = (op_s3_reg.is_edge && op_s3_reg.part) ? (acc_reg - prod_ext)
                                                         : (acc_reg + prod_ext);
        if ((!op_s3_reg.is_edge && op_s3_reg.first) || (op_s3_reg.is_edge && !op_s3_reg.part))
        begin
            acc_next = prod_ext;
        end
        else
        begin
            acc_next = sum;
        end
        sum_pos = !sum[ACC_W-1] && (|sum);
        sum_neg = sum[ACC_W-1];
        cw_next = cw_reg;
        if (op_s3_reg.valid && !op_s3_reg.is_edge && op_s3_reg.last)
        begin
            cw_next = sum_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_s1_reg <= '0;
            op_s2_reg <= '0;
            op_s3_reg <= '0;
            cw_reg    <= 1'b0;
        end
        else
        begin
            op_s1_reg <= op;
            op_s2_reg <= op_s1_reg;
            op_s3_reg <= op_s2_reg;
            cw_reg    <= cw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        prod_reg <= opa_reg * opb_reg;
        if (op_s3_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        res.valid  = op_s3_reg.valid && op_s3_reg.is_edge && op_s3_reg.part;
        res.facing = cw_reg ? sum_pos : sum_neg;
        res.last   = op_s3_reg.last;
        res.idx    = op_s3_reg.idx;
    end

    assign cw = cw_reg;

endmodule
`default_nettype wire

[sv/pefc_chk.sv]
// Port checker for the classifier, bound to the top level.
`default_nettype none
module pefc_chk
    import pefc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              command,
    input wire logic              done,
    input wire logic [MASK_W-1:0] facing_mask,
    input wire logic [CNT_W-1:0]  facing_count
);

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_QUERY) |=> busy)
        else $error("query transfer did not raise busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_LOAD) |=> !busy)
        else $error("load transfer raised busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(facing_count) == $countones(facing_mask)))
        else $error("facing_count disagrees with facing_mask");

endmodule

bind polygon_edge_facing_classifier pefc_chk u_pefc_chk (.*);
`default_nettype wire
